// ----- hw/rtl/bucketed_key_lookup_table_top_assert.svh -----
// Assertion macros for the lookup table; each checks on the rising clock edge
// and is disabled while reset is high.
`ifndef BUCKETED_KEY_LOOKUP_TABLE_TOP_ASSERT_SVH
`define BUCKETED_KEY_LOOKUP_TABLE_TOP_ASSERT_SVH

// Condition holds on every edge out of reset.
`define BKLT_ASSERT_ALWAYS(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define BKLT_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define BKLT_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/bklt_pkg.sv -----
`timescale 1ns / 1ps

package bklt_pkg;

   localparam int ENTRIES     = 32;
   localparam int BUCKETS     = 32;   // power of two: bucket is a bit field of the key
   localparam int KEY_BITS    = 48;
   localparam int VALUE_BITS  = 48;
   localparam int INDEX_BITS  = 8;
   localparam int HASH_SHIFT  = 8;
   localparam int MAX_INDEX   = 31;
   localparam int INDEX_SHIFT = 3;

   localparam int SLOT_W   = $clog2(MAX_INDEX + 1);
   localparam int ADDR_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int BUCKET_W = $clog2(BUCKETS);
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   typedef logic [CNT_W-1:0]      cnt_type;
   typedef logic [ADDR_W-1:0]     addr_type;
   typedef logic [BUCKET_W-1:0]   bucket_type;
   typedef logic [KEY_BITS-1:0]   key_type;
   typedef logic [VALUE_BITS-1:0] value_type;
   typedef logic [INDEX_BITS-1:0] index_type;

   localparam cnt_type CNT_ONE  = cnt_type'(1);
   localparam cnt_type CNT_FULL = cnt_type'(ENTRIES);

   typedef enum logic [1:0] {
      FUNC_CLEAR  = 2'd0,
      FUNC_LOAD   = 2'd1,
      FUNC_LOOKUP = 2'd2
   } func_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_MISS  = 2'd1,
      ST_FULL  = 2'd2,
      ST_RANGE = 2'd3
   } status_type;

   typedef struct packed {
      key_type           key;
      value_type         value;
      logic [SLOT_W-1:0] slot;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   function automatic bucket_type bucket_of(input key_type k);
      return k[HASH_SHIFT +: BUCKET_W];
   endfunction

endpackage

// ----- hw/rtl/bklt_ram.sv -----
`timescale 1ns / 1ps

module bklt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/bucketed_key_lookup_table_top.sv -----
`timescale 1ns / 1ps
`include "bucketed_key_lookup_table_top_assert.svh"

// Channel   Dir  tdata (low bit up)                     tuser (low bit up)
// req_      in   key[47:0] value[95:48] index[103:96]   func[1:0]
// rsp_      out  found_value[47:0] index_code[55:48]    hit[0] status[2:1]
//
// Clear and load go from accept straight to the pending result (S_DONE) and
// then accept again. Lookup first reads n entries from the entry RAM: the
// scan runs newest-first, one RAM read a cycle, and stops at the first key
// match or once every entry of the key's bucket is seen (n <= 32, 0 for an
// empty bucket). Reset clears entry count and bucket counters.
// One item is in work at a time; a finished result waits in a pending stage
// behind the output register, so a stalled rsp_ side holds up to two items.

module bucketed_key_lookup_table_top (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  logic [103:0]  req_tdata,   // key[47:0], value[95:48], index[103:96]
   input  logic [1:0]    req_tuser,   // func[1:0]
   output logic          rsp_tvalid,
   input  logic          rsp_tready,
   output logic [55:0]   rsp_tdata,   // found_value[47:0], index_code[55:48]
   output logic [2:0]    rsp_tuser    // hit[0], status[2:1]
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // control state
   state_type                      state_ff, state_in;
   bklt_pkg::cnt_type              entry_count_ff, entry_count_in;
   bklt_pkg::cnt_type              bucket_count_ff [bklt_pkg::BUCKETS];
   bklt_pkg::cnt_type              remain_ff, remain_in;
   bklt_pkg::addr_type             ptr_ff, ptr_in;
   bklt_pkg::key_type              key_ff, key_in;
   logic                           out_valid_ff, out_valid_in;

   // pending result and output register payload
   logic                           res_hit_ff, res_hit_in;
   bklt_pkg::value_type            res_value_ff, res_value_in;
   bklt_pkg::index_type            res_code_ff, res_code_in;
   bklt_pkg::status_type           res_status_ff, res_status_in;
   logic                           out_hit_ff, out_hit_in;
   bklt_pkg::value_type            out_value_ff, out_value_in;
   bklt_pkg::index_type            out_code_ff, out_code_in;
   bklt_pkg::status_type           out_status_ff, out_status_in;

   // item fields
   logic                           req_acc;
   bklt_pkg::func_type             in_func;
   bklt_pkg::key_type              in_key;
   bklt_pkg::value_type            in_value;
   bklt_pkg::index_type            in_index;
   bklt_pkg::bucket_type           in_bucket;
   logic                           load_ok;
   logic                           bump_bucket;
   logic                           clear_buckets;

   // entry RAM
   logic                           ram_wr_en;
   bklt_pkg::entry_type            ram_wr_data;
   logic                           ram_rd_en;
   bklt_pkg::addr_type             ram_rd_addr;
   logic [bklt_pkg::ENTRY_W-1:0]   ram_rd_raw;
   bklt_pkg::entry_type            rd_entry;
   bklt_pkg::cnt_type              remain_dec;
   bklt_pkg::cnt_type              count_m1;
   logic                           out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign in_func    = bklt_pkg::func_type'(req_tuser[1:0]);
   assign in_key     = req_tdata[47:0];
   assign in_value   = req_tdata[95:48];
   assign in_index   = req_tdata[103:96];
   assign in_bucket  = bklt_pkg::bucket_of(in_key);
   assign load_ok    = (in_index <= bklt_pkg::index_type'(bklt_pkg::MAX_INDEX)) &&
                       (entry_count_ff < bklt_pkg::CNT_FULL);
   assign count_m1   = entry_count_ff - bklt_pkg::CNT_ONE;
   assign rd_entry   = bklt_pkg::entry_type'(ram_rd_raw);
   assign out_free   = !out_valid_ff || rsp_tready;

   // new entries go to the slot at the current fill count
   assign ram_wr_data.key   = in_key;
   assign ram_wr_data.value = in_value;
   assign ram_wr_data.slot  = in_index[bklt_pkg::SLOT_W-1:0];

   bklt_ram #(
      .WIDTH (bklt_pkg::ENTRY_W),
      .DEPTH (bklt_pkg::ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (entry_count_ff[bklt_pkg::ADDR_W-1:0]),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_raw)
   );

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      remain_in      = remain_ff;
      ptr_in         = ptr_ff;
      key_in         = key_ff;
      res_hit_in     = res_hit_ff;
      res_value_in   = res_value_ff;
      res_code_in    = res_code_ff;
      res_status_in  = res_status_ff;
      out_valid_in   = out_valid_ff && !rsp_tready;
      out_hit_in     = out_hit_ff;
      out_value_in   = out_value_ff;
      out_code_in    = out_code_ff;
      out_status_in  = out_status_ff;
      ram_wr_en      = 1'b0;
      ram_rd_en      = 1'b0;
      ram_rd_addr    = ptr_ff - bklt_pkg::addr_type'(1);
      bump_bucket    = 1'b0;
      clear_buckets  = 1'b0;
      remain_dec     = remain_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               // default result: all zero, status ok
               res_hit_in    = 1'b0;
               res_value_in  = '0;
               res_code_in   = '0;
               res_status_in = bklt_pkg::ST_OK;
               key_in        = in_key;
               state_in      = S_DONE;
               case (in_func)
                  bklt_pkg::FUNC_CLEAR: begin
                     entry_count_in = '0;
                     clear_buckets  = 1'b1;
                  end
                  bklt_pkg::FUNC_LOAD: begin
                     if (in_index > bklt_pkg::index_type'(bklt_pkg::MAX_INDEX)) begin
                        res_status_in = bklt_pkg::ST_RANGE;
                     end else if (!load_ok) begin
                        res_status_in = bklt_pkg::ST_FULL;
                     end else begin
                        ram_wr_en      = 1'b1;
                        bump_bucket    = 1'b1;
                        entry_count_in = entry_count_ff + bklt_pkg::CNT_ONE;
                     end
                  end
                  bklt_pkg::FUNC_LOOKUP: begin
                     res_status_in = bklt_pkg::ST_MISS;
                     // empty bucket: answer miss without touching the RAM
                     if (bucket_count_ff[in_bucket] != '0) begin
                        remain_in   = bucket_count_ff[in_bucket];
                        ptr_in      = count_m1[bklt_pkg::ADDR_W-1:0];
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = count_m1[bklt_pkg::ADDR_W-1:0];
                        state_in    = S_SCAN;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            // RAM output holds the entry at ptr_ff
            if (rd_entry.key == key_ff) begin
               res_hit_in    = 1'b1;
               res_value_in  = rd_entry.value;
               res_code_in   = bklt_pkg::index_type'(rd_entry.slot) << bklt_pkg::INDEX_SHIFT;
               res_status_in = bklt_pkg::ST_OK;
               state_in      = S_DONE;
            end else begin
               if (bklt_pkg::bucket_of(rd_entry.key) == bklt_pkg::bucket_of(key_ff)) begin
                  remain_dec = remain_ff - bklt_pkg::CNT_ONE;
               end
               remain_in = remain_dec;
               // stop once every entry of this bucket has been seen
               if (remain_dec == '0 || ptr_ff == '0) begin
                  state_in = S_DONE;
               end else begin
                  ram_rd_en = 1'b1;
                  ptr_in    = ptr_ff - bklt_pkg::addr_type'(1);
               end
            end
         end
         S_DONE: begin
            // advance the pending result once the output register frees up
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_hit_in    = res_hit_ff;
               out_value_in  = res_value_ff;
               out_code_in   = res_code_ff;
               out_status_in = res_status_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         entry_count_ff <= '0;
         remain_ff      <= '0;
         ptr_ff         <= '0;
         out_valid_ff   <= 1'b0;
         for (int b = 0; b < bklt_pkg::BUCKETS; b++) begin
            bucket_count_ff[b] <= '0;
         end
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         remain_ff      <= remain_in;
         ptr_ff         <= ptr_in;
         out_valid_ff   <= out_valid_in;
         for (int b = 0; b < bklt_pkg::BUCKETS; b++) begin
            if (clear_buckets) begin
               bucket_count_ff[b] <= '0;
            end else if (bump_bucket && (in_bucket == bklt_pkg::bucket_type'(b))) begin
               bucket_count_ff[b] <= bucket_count_ff[b] + bklt_pkg::CNT_ONE;
            end
         end
      end
      key_ff        <= key_in;
      res_hit_ff    <= res_hit_in;
      res_value_ff  <= res_value_in;
      res_code_ff   <= res_code_in;
      res_status_ff <= res_status_in;
      out_hit_ff    <= out_hit_in;
      out_value_ff  <= out_value_in;
      out_code_ff   <= out_code_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_code_ff, out_value_ff};
   assign rsp_tuser  = {out_status_ff, out_hit_ff};

   `BKLT_ASSERT_ALWAYS(a_count_bound, entry_count_ff <= bklt_pkg::CNT_FULL, "entry count overflow")
   `BKLT_ASSERT_IMPLIES(a_scan_live, state_ff == S_SCAN, (remain_ff != '0) && (bklt_pkg::cnt_type'(ptr_ff) < entry_count_ff), "scan past valid entries")
   `BKLT_ASSERT_IMPLIES(a_hit_ok, out_valid_ff && out_hit_ff, out_status_ff == bklt_pkg::ST_OK, "hit without ok status")
   `BKLT_ASSERT_NEXT(a_load_count, req_acc && in_func == bklt_pkg::FUNC_LOAD && load_ok, entry_count_ff == $past(entry_count_ff) + bklt_pkg::CNT_ONE, "load did not advance count")

endmodule

// ----- bench/lookup_table_checker.sv -----
`timescale 1ns / 1ps

// Watches both channels of the lookup table, keeps a shadow copy of the table
// and compares every response against the oldest predicted answer.
module lookup_table_checker (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  logic          req_tready,
   input  logic [103:0]  req_tdata,   // key[47:0], value[95:48], index[103:96]
   input  logic [1:0]    req_tuser,   // func[1:0]
   input  logic          rsp_tvalid,
   input  logic          rsp_tready,
   input  logic [55:0]   rsp_tdata,   // found_value[47:0], index_code[55:48]
   input  logic [2:0]    rsp_tuser,   // hit[0], status[2:1]
   output int            fail_count,
   output int            outstanding,
   output int            hit_count
);

   typedef struct packed {
      logic                 hit;
      bklt_pkg::value_type  found_value;
      bklt_pkg::index_type  index_code;
      bklt_pkg::status_type status;
   } answer_type;

   bklt_pkg::key_type   shadow_keys[bklt_pkg::ENTRIES];
   bklt_pkg::value_type shadow_values[bklt_pkg::ENTRIES];
   bklt_pkg::index_type shadow_slots[bklt_pkg::ENTRIES];
   int                  bucket_fill[bklt_pkg::BUCKETS];
   int                  loaded_n;
   answer_type          answer_q[$];

   // Apply one item to the shadow table and return the answer it must produce.
   function automatic answer_type apply_table_op(logic [1:0] fn, bklt_pkg::key_type k,
                                                 bklt_pkg::value_type v,
                                                 bklt_pkg::index_type ix);
      answer_type a;
      bklt_pkg::bucket_type b;
      a = '0;
      a.status = bklt_pkg::ST_OK;
      b = k[bklt_pkg::HASH_SHIFT +: bklt_pkg::BUCKET_W];
      case (fn)
         bklt_pkg::FUNC_CLEAR: begin
            loaded_n = 0;
            foreach (bucket_fill[i]) bucket_fill[i] = 0;
         end
         bklt_pkg::FUNC_LOAD: begin
            // range check wins over the full check
            if (ix > bklt_pkg::MAX_INDEX) begin
               a.status = bklt_pkg::ST_RANGE;
            end else if (loaded_n >= bklt_pkg::ENTRIES) begin
               a.status = bklt_pkg::ST_FULL;
            end else begin
               shadow_keys[loaded_n]   = k;
               shadow_values[loaded_n] = v;
               shadow_slots[loaded_n]  = ix;
               bucket_fill[b]++;
               loaded_n++;
            end
         end
         bklt_pkg::FUNC_LOOKUP: begin
            a.status = bklt_pkg::ST_MISS;
            // newest entry first, so a reloaded key shadows the older one
            if (bucket_fill[b] != 0) begin
               for (int i = loaded_n - 1; i >= 0 && !a.hit; i--) begin
                  if (shadow_keys[i] == k) begin
                     a.hit         = 1'b1;
                     a.found_value = shadow_values[i];
                     a.index_code  = shadow_slots[i] << bklt_pkg::INDEX_SHIFT;
                     a.status      = bklt_pkg::ST_OK;
                  end
               end
            end
         end
         default: ;   // unused code: no state change, all-zero answer
      endcase
      return a;
   endfunction

   task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : watch
      answer_type want;
      answer_type got;
      if (reset) begin
         loaded_n = 0;
         foreach (bucket_fill[i]) bucket_fill[i] = 0;
         answer_q.delete();
         fail_count = 0;
         hit_count  = 0;
      end else begin
         // responses first: one accepted on this edge cannot belong to a
         // request accepted on the same edge
         if (rsp_tvalid && rsp_tready) begin
            got.hit         = rsp_tuser[0];
            got.status      = bklt_pkg::status_type'(rsp_tuser[2:1]);
            got.found_value = rsp_tdata[47:0];
            got.index_code  = rsp_tdata[55:48];
            if (got.hit) hit_count++;
            if (answer_q.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual %0h", $time, got);
               fail_count++;
            end else begin
               want = answer_q.pop_front();
               check_field("hit", want.hit, got.hit);
               check_field("found_value", want.found_value, got.found_value);
               check_field("index_code", want.index_code, got.index_code);
               check_field("status", want.status, got.status);
            end
         end
         if (req_tvalid && req_tready)
            answer_q.push_back(apply_table_op(req_tuser, req_tdata[47:0], req_tdata[95:48],
                                              req_tdata[103:96]));
      end
      outstanding <= answer_q.size();
   end

endmodule

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

// Stimulus and verdict for the bucketed key lookup table. The checker beside
// the block predicts and compares; this module only drives items, shapes the
// back-pressure and reports the outcome.
module testbench;

   localparam int           RANDOM_ITEMS   = 660;
   localparam int           POOL_N         = 12;
   localparam int           HOLDOFF_CYCLES = 300;
   localparam int           SETTLE_CYCLES  = 40;
   localparam int           CYCLE_LIMIT    = 500000;
   localparam logic [1:0]   FUNC_UNUSED    = 2'd3;  // no operation behind this code

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_tvalid = 1'b0;
   logic          req_tready;
   logic [103:0]  req_tdata = '0;    // key[47:0], value[95:48], index[103:96]
   logic [1:0]    req_tuser = '0;    // func[1:0]
   logic          rsp_tvalid;
   logic          rsp_tready = 1'b0;
   logic [55:0]   rsp_tdata;         // found_value[47:0], index_code[55:48]
   logic [2:0]    rsp_tuser;         // hit[0], status[2:1]

   int fail_count;
   int outstanding;
   int hit_count;

   // back-pressure knobs, in percent, changed per phase
   int send_idle_pct = 0;
   int stall_pct = 0;

   // one long receiver hold-off, requested once by the stimulus
   bit holdoff_go = 1'b0;
   bit holdoff_taken = 1'b0;
   int holdoff_left = 0;

   int cycle_n = 0;
   int sent_n = 0;
   int clear_n = 0;
   int load_n = 0;
   int lookup_n = 0;
   int unused_n = 0;

   // keys of the current session; about half are crowded into two buckets so
   // that lookups scan long chains and see duplicates
   bklt_pkg::key_type key_pool[POOL_N];

   bucketed_key_lookup_table_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   lookup_table_checker lookup_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .fail_count  (fail_count),
      .outstanding (outstanding),
      .hit_count   (hit_count)
   );

   always #10 clock = ~clock;

   // Receiver: random stalls per the current phase, except while the long
   // hold-off runs; the hold-off counts its own cycles here.
   always @(posedge clock) begin
      if (holdoff_go && !holdoff_taken) begin
         holdoff_taken <= 1'b1;
         holdoff_left  <= HOLDOFF_CYCLES;
         rsp_tready    <= 1'b0;
      end else if (holdoff_left != 0) begin
         holdoff_left <= holdoff_left - 1;
         rsp_tready   <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Watchdog: a stuck handshake ends the run here.
   always @(posedge clock) begin
      cycle_n <= cycle_n + 1;
      if (cycle_n == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses still due", cycle_n, outstanding);
         $display("testbench: FAIL");
         $finish;
      end
   end

   function automatic bklt_pkg::value_type random_word();
      return bklt_pkg::value_type'({$urandom, $urandom});
   endfunction

   // mostly legal slots, now and then one above the limit
   function automatic bklt_pkg::index_type random_slot();
      if ($urandom_range(7) == 0)
         return bklt_pkg::index_type'($urandom_range(255, bklt_pkg::MAX_INDEX + 1));
      return bklt_pkg::index_type'($urandom_range(bklt_pkg::MAX_INDEX));
   endfunction

   // lookup key: mostly a pool key, some foreign keys, some pool keys with a
   // bit flipped outside the hash field (same bucket, no match)
   function automatic bklt_pkg::key_type probe_key();
      bklt_pkg::key_type k;
      k = key_pool[$urandom_range(POOL_N - 1)];
      case ($urandom_range(9))
         0: k = random_word();
         1: k ^= bklt_pkg::key_type'(1) << ($urandom_range(1) ? bklt_pkg::KEY_BITS - 1
                                            : $urandom_range(bklt_pkg::HASH_SHIFT - 1));
         default: ;
      endcase
      return k;
   endfunction

   // Offer one item and hold it until accepted. valid stays high on return so
   // that a following item goes out back to back; drop it with idle_bus().
   task automatic send_item(logic [1:0] fn, bklt_pkg::key_type k, bklt_pkg::value_type v,
                            bklt_pkg::index_type ix);
      if ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {ix, v, k};
      req_tuser  <= fn;
      do @(posedge clock); while (!req_tready);
      sent_n++;
      case (fn)
         bklt_pkg::FUNC_CLEAR:  clear_n++;
         bklt_pkg::FUNC_LOAD:   load_n++;
         bklt_pkg::FUNC_LOOKUP: lookup_n++;
         default:               unused_n++;
      endcase
   endtask

   // Drop valid and hold until every predicted response has come back.
   task automatic idle_bus();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // One session: usually clear, fill with pool keys (sometimes past full),
   // probe along the way, then probe some more; a little noise throughout.
   task automatic run_session();
      bklt_pkg::bucket_type hot_a;
      bklt_pkg::bucket_type hot_b;
      int loads;
      int probes;
      int i;
      hot_a = bklt_pkg::bucket_type'($urandom);
      hot_b = bklt_pkg::bucket_type'($urandom);
      for (i = 0; i < POOL_N; i++) begin
         key_pool[i] = random_word();
         if ($urandom_range(1))
            key_pool[i][bklt_pkg::HASH_SHIFT +: bklt_pkg::BUCKET_W] =
               $urandom_range(1) ? hot_a : hot_b;
      end
      if ($urandom_range(3) != 0)
         send_item(bklt_pkg::FUNC_CLEAR, random_word(), random_word(),
                   bklt_pkg::index_type'($urandom));
      loads = $urandom_range(40, 1);
      for (i = 0; i < loads; i++) begin
         send_item(bklt_pkg::FUNC_LOAD, key_pool[$urandom_range(POOL_N - 1)], random_word(),
                   random_slot());
         if ($urandom_range(3) == 0)
            send_item(bklt_pkg::FUNC_LOOKUP, probe_key(), random_word(),
                      bklt_pkg::index_type'($urandom));
      end
      probes = $urandom_range(20, 6);
      for (i = 0; i < probes; i++) begin
         case ($urandom_range(29))
            0:       send_item(FUNC_UNUSED, random_word(), random_word(),
                               bklt_pkg::index_type'($urandom));
            1:       send_item(bklt_pkg::FUNC_CLEAR, random_word(), random_word(),
                               random_slot());
            default: send_item(bklt_pkg::FUNC_LOOKUP, probe_key(), random_word(),
                               bklt_pkg::index_type'($urandom));
         endcase
      end
   endtask

   initial begin
      int phase;
      int goal;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_item(bklt_pkg::FUNC_LOOKUP, '0, '0, '0);           // empty table misses
      send_item(FUNC_UNUSED, '1, '1, '1);                     // unused code, ignored
      send_item(bklt_pkg::FUNC_LOAD, '1, '1,
                bklt_pkg::index_type'(bklt_pkg::MAX_INDEX));  // all-ones key, top slot
      send_item(bklt_pkg::FUNC_LOAD, '0, '0, '0);             // all-zero key, slot 0
      send_item(bklt_pkg::FUNC_LOAD, '0, '1,
                bklt_pkg::index_type'(bklt_pkg::MAX_INDEX + 1)); // first slot out of range
      send_item(bklt_pkg::FUNC_LOAD, '1, '0, '1);             // largest slot, rejected
      send_item(bklt_pkg::FUNC_LOOKUP, '1, '0, '0);           // hit, code 248
      send_item(bklt_pkg::FUNC_LOOKUP, '0, '1, '1);           // hit, code 0
      send_item(bklt_pkg::FUNC_LOAD, '0, 48'h1234_5678_9abc, 8'd5); // duplicate key
      send_item(bklt_pkg::FUNC_LOOKUP, '0, '0, '0);           // newest copy wins
      send_item(bklt_pkg::FUNC_LOOKUP, 48'h1, '0, '0);        // same bucket, no match
      send_item(bklt_pkg::FUNC_LOOKUP, 48'h100, '0, '0);      // untouched bucket
      send_item(bklt_pkg::FUNC_CLEAR, '1, '1, '1);
      send_item(bklt_pkg::FUNC_LOOKUP, '1, '0, '0);           // gone after clear
      idle_bus();

      // random phases: no idling (with the long hold-off), sender idle,
      // receiver stalling, both lightly
      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  holdoff_go <= 1'b1; end
            1: begin send_idle_pct = 63; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 63; end
            default: begin send_idle_pct = 11; stall_pct = 11; end
         endcase
         goal = sent_n + RANDOM_ITEMS / 4;
         while (sent_n < goal) run_session();
         idle_bus();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("sent %0d items: %0d clears, %0d loads, %0d lookups, %0d unused codes",
               sent_n, clear_n, load_n, lookup_n, unused_n);
      $display("%0d lookups hit; ran idle, stalled and held-off phases in %0d cycles",
               hit_count, cycle_n);
      if (fail_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("%0d mismatches", fail_count);
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
